[rtl/fault_list_manager_core_defines.svh]
// ---------------------------------------------------------------------------
// Fault list manager assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef FAULT_LIST_MANAGER_CORE_DEFINES_SVH
`define FAULT_LIST_MANAGER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define FLM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fault list manager assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define FLM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fault list manager assertion failed");
`else
`define FLM_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define FLM_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[rtl/flm_pkg.sv]
// ---------------------------------------------------------------------------
// Fault list manager package
// Record layout, operation codes and command types shared by the cells,
// the per-axis rows and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package flm_pkg;

	// Default sizes
	localparam int LIST_DEPTH_DEF    = 8;
	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int AXES_DEF          = 2;

	localparam int CODE_W = 8;

	// One fault record: code in the low bits, attributes above
	typedef struct packed {
		logic              stop;
		logic              clr;
		logic              hist;
		logic [CODE_W-1:0] code;
	} rec_t;

	// Operation carried in tuser
	typedef enum logic [1:0] {
		OP_REPORT    = 2'd0,
		OP_CLR       = 2'd1,
		OP_CODE      = 2'd2,
		OP_CLR_HIST  = 2'd3
	} op_t;

	// Command from the sequencer to one axis row
	typedef enum logic [2:0] {
		CMD_HOLD      = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_MARK_CLR  = 3'd2,
		CMD_MARK_CODE = 3'd3,
		CMD_COMPACT   = 3'd4,
		CMD_FIN_HEAD  = 3'd5,
		CMD_FIN_CLR   = 3'd6,
		CMD_FIN_CODE  = 3'd7
	} row_cmd_t;

	// Command from a row to each of its list cells
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_SHIFT = 2'd1,
		CELL_MARK  = 2'd2,
		CELL_PULL  = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		row_cmd_t cmd;
		logic     wipe_hist;
		rec_t     rec;
	} row_ctrl_t;

	typedef struct packed {
		logic              found;
		logic              pending;
		rec_t              cur_nxt;
		logic [CODE_W-1:0] newest;
	} row_stat_t;

	// Result item, last field in the lowest bits
	typedef struct packed {
		logic [CODE_W-1:0] newest_logged;
		logic              head_history;
		logic              head_stop;
		logic              head_clearable;
		logic [CODE_W-1:0] head_code;
		logic [3:0]        fault_count;
		logic              fault_active;
	} res_t;

endpackage

`default_nettype wire

[rtl/flm_cell.sv]
// ---------------------------------------------------------------------------
// Fault list cell
// One slot of the current-fault list. Shifts toward the tail on insert,
// zeroes itself on a matching clear and pulls from its tail neighbor while
// a hole lies at or ahead of it.
// ---------------------------------------------------------------------------
`default_nettype none

module flm_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  flm_pkg::cell_cmd_t  cmd,
	input  wire                 mark_clr,
	input  wire  [flm_pkg::CODE_W-1:0] key,
	input  flm_pkg::rec_t       prev_rec,
	input  flm_pkg::rec_t       next_rec,
	input  wire                 hole_in,
	output flm_pkg::rec_t       rec,
	output logic                hole_out,
	output logic                match,
	output logic                pending
);

	flm_pkg::rec_t rec_q;
	logic          empty;
	logic          kill;

	// Slot status
	assign empty    = (rec_q.code == '0);
	assign match    = !empty && (rec_q.code == key);
	assign hole_out = hole_in || empty;
	assign pending  = hole_in && !empty;
	assign kill     = mark_clr ? (!empty && rec_q.clr) : match;
	assign rec      = rec_q;

	// Update the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			case (cmd)
				flm_pkg::CELL_SHIFT: begin
					rec_q <= prev_rec;
				end
				flm_pkg::CELL_MARK: begin
					if (kill) begin
						rec_q <= '0;
					end
				end
				flm_pkg::CELL_PULL: begin
					if (hole_out) begin
						rec_q <= next_rec;
					end
				end
				default: begin
					rec_q <= rec_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/flm_row.sv]
// ---------------------------------------------------------------------------
// Fault list row
// State of one axis: a chain of list cells, the history shift line and the
// current fault record, plus the entry count of the packed list.
// ---------------------------------------------------------------------------
`default_nettype none

module flm_row #(
	parameter int LIST_DEPTH    = flm_pkg::LIST_DEPTH_DEF,
	parameter int HISTORY_DEPTH = flm_pkg::HISTORY_DEPTH_DEF,
	parameter int CNT_W         = $clog2(LIST_DEPTH + 1)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  flm_pkg::row_ctrl_t  ctrl,
	output flm_pkg::row_stat_t  stat,
	output logic [CNT_W-1:0]    count
);

	flm_pkg::rec_t      rec_w   [LIST_DEPTH];
	logic [LIST_DEPTH:0] hole_w;
	logic [LIST_DEPTH-1:0] match_w;
	logic [LIST_DEPTH-1:0] pend_w;
	logic [LIST_DEPTH:0] occ_w;
	flm_pkg::cell_cmd_t cell_cmd;
	logic               mark_clr;
	flm_pkg::rec_t      cur_q;
	flm_pkg::rec_t      cur_nxt;
	logic [flm_pkg::CODE_W-1:0] hist_q [HISTORY_DEPTH];
	logic               hist_push;
	logic               hist_wipe;

	// Map the row command onto the cell command
	always_comb begin
		case (ctrl.cmd)
			flm_pkg::CMD_INSERT:    cell_cmd = flm_pkg::CELL_SHIFT;
			flm_pkg::CMD_MARK_CLR:  cell_cmd = flm_pkg::CELL_MARK;
			flm_pkg::CMD_MARK_CODE: cell_cmd = flm_pkg::CELL_MARK;
			flm_pkg::CMD_COMPACT:   cell_cmd = flm_pkg::CELL_PULL;
			default:                cell_cmd = flm_pkg::CELL_HOLD;
		endcase
	end
	assign mark_clr = (ctrl.cmd == flm_pkg::CMD_MARK_CLR);

	assign hole_w[0] = 1'b0;

	// Chain of list cells, head at index 0
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		flm_pkg::rec_t prev_w;
		flm_pkg::rec_t next_w;

		if (i == 0) begin : g_head
			assign prev_w = ctrl.rec;
		end else begin : g_body
			assign prev_w = rec_w[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_tail
			assign next_w = '0;
		end else begin : g_inner
			assign next_w = rec_w[i+1];
		end

		flm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cell_cmd),
			.mark_clr (mark_clr),
			.key      (ctrl.rec.code),
			.prev_rec (prev_w),
			.next_rec (next_w),
			.hole_in  (hole_w[i]),
			.rec      (rec_w[i]),
			.hole_out (hole_w[i+1]),
			.match    (match_w[i]),
			.pending  (pend_w[i])
		);

		assign occ_w[i] = (rec_w[i].code != '0);
	end
	assign occ_w[LIST_DEPTH] = 1'b0;

	// Count of the packed list: position of the last occupied slot
	always_comb begin
		count = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (occ_w[i] && !occ_w[i+1]) begin
				count = count | CNT_W'(i + 1);
			end
		end
	end

	// Next current record
	always_comb begin
		case (ctrl.cmd)
			flm_pkg::CMD_FIN_HEAD: begin
				cur_nxt = rec_w[0];
			end
			flm_pkg::CMD_FIN_CLR: begin
				cur_nxt = cur_q.clr ? '0 : cur_q;
			end
			flm_pkg::CMD_FIN_CODE: begin
				cur_nxt = (cur_q.code == ctrl.rec.code) ? '0 : cur_q;
				if (occ_w[0]) begin
					cur_nxt = rec_w[0];
				end
			end
			default: begin
				cur_nxt = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else begin
			cur_q <= cur_nxt;
		end
	end

	// History shift line, newest at index 0
	assign hist_push = (ctrl.cmd == flm_pkg::CMD_INSERT) && ctrl.rec.hist;
	assign hist_wipe = (ctrl.cmd == flm_pkg::CMD_MARK_CLR) && ctrl.wipe_hist;

	for (genvar h = 0; h < HISTORY_DEPTH; h++) begin : g_hist
		logic [flm_pkg::CODE_W-1:0] feed_w;

		if (h == 0) begin : g_first
			assign feed_w = ctrl.rec.code;
		end else begin : g_next
			assign feed_w = hist_q[h-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q[h] <= '0;
			end else if (hist_wipe) begin
				hist_q[h] <= '0;
			end else if (hist_push) begin
				hist_q[h] <= feed_w;
			end
		end
	end

	// Row status
	assign stat.found   = |match_w;
	assign stat.pending = |pend_w;
	assign stat.cur_nxt = cur_nxt;
	assign stat.newest  = hist_q[0];

endmodule

`default_nettype wire

[rtl/fault_list_manager_core.sv]
// ---------------------------------------------------------------------------
// Fault list manager core
// Per-axis fault lists with deduplicated newest-first ordering, a history
// shift line and a current fault record. Each input transfer carries one
// operation for one axis (report, clear clearable, clear one code, clear
// clearable and empty the history) and yields exactly one result transfer
// with the axis state after the operation. Items are handled one at a time:
// an item passes through execute, settle and finish steps before its result
// is presented. The settle step lasts while list compaction is pending,
// which the cell chain performs one slot shift per cycle after a clear that
// leaves holes ahead of live entries. The input is ready again in the cycle
// after the result is loaded. The finish step waits while the output
// register still holds an unaccepted result. A new item is accepted as soon
// as the sequencer is idle, even while the previous result still waits in
// the output register. Axis numbers at or above AXES leave all state
// untouched and return an all-zero result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fault_list_manager_core_defines.svh"

module fault_list_manager_core #(
	parameter int LIST_DEPTH    = flm_pkg::LIST_DEPTH_DEF,
	parameter int HISTORY_DEPTH = flm_pkg::HISTORY_DEPTH_DEF,
	parameter int AXES          = flm_pkg::AXES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // fault_code[7:0], log_history, may_clear, stop_now, zero pad
	input  wire  [2:0]  s_tuser,  // operation[1:0], axis
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata   // fault_active, fault_count[3:0], head_code[7:0],
	                              // head_clearable, head_stop, head_history,
	                              // newest_logged[7:0]
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_EXEC    = 4'b0010,
		S_COMPACT = 4'b0100,
		S_FINISH  = 4'b1000
	} state_t;

	state_t             state_q;
	state_t             state_nxt;
	flm_pkg::op_t       op_q;
	logic               axis_q;
	flm_pkg::rec_t      item_q;
	logic               axis_ok;
	logic               code_nz;
	logic               in_xfer;
	logic               fin_take;
	flm_pkg::row_cmd_t  cmd;
	flm_pkg::row_ctrl_t ctrl_w [AXES];
	flm_pkg::row_stat_t stat_w [AXES];
	logic [CNT_W-1:0]   cnt_w  [AXES];
	flm_pkg::row_stat_t sel_stat;
	logic [CNT_W-1:0]   sel_cnt;
	logic [CNT_W+3:0]   cnt_ext;
	flm_pkg::res_t      res;
	flm_pkg::res_t      out_q;
	logic               m_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign axis_ok  = (32'(axis_q) < AXES);
	assign code_nz  = (item_q.code != '0);
	assign fin_take = (state_q == S_FINISH) && (!m_valid_q || m_tready);

	// Capture the item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= flm_pkg::op_t'(s_tuser[1:0]);
			axis_q <= s_tuser[2];
			item_q <= s_tdata[10:0];
		end
	end

	// Pick the addressed row's status
	always_comb begin
		sel_stat = '0;
		sel_cnt  = '0;
		for (int a = 0; a < AXES; a++) begin
			if (axis_ok && (32'(axis_q) == a)) begin
				sel_stat = stat_w[a];
				sel_cnt  = cnt_w[a];
			end
		end
	end

	// Sequence the row command and the next state
	always_comb begin
		cmd       = flm_pkg::CMD_HOLD;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					flm_pkg::OP_REPORT: begin
						if (code_nz && !sel_stat.found) begin
							cmd = flm_pkg::CMD_INSERT;
						end
					end
					flm_pkg::OP_CODE: begin
						if (code_nz) begin
							cmd = flm_pkg::CMD_MARK_CODE;
						end
					end
					default: begin
						cmd = flm_pkg::CMD_MARK_CLR;
					end
				endcase
				state_nxt = S_COMPACT;
			end
			S_COMPACT: begin
				if (sel_stat.pending) begin
					cmd = flm_pkg::CMD_COMPACT;
				end else begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (fin_take) begin
					case (op_q)
						flm_pkg::OP_REPORT: begin
							if (code_nz) begin
								cmd = flm_pkg::CMD_FIN_HEAD;
							end
						end
						flm_pkg::OP_CODE: begin
							if (code_nz) begin
								cmd = flm_pkg::CMD_FIN_CODE;
							end
						end
						default: begin
							cmd = flm_pkg::CMD_FIN_CLR;
						end
					endcase
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// One row per axis; only the addressed row sees the command
	for (genvar a = 0; a < AXES; a++) begin : g_axis
		assign ctrl_w[a].cmd       = (axis_ok && (32'(axis_q) == a)) ? cmd : flm_pkg::CMD_HOLD;
		assign ctrl_w[a].wipe_hist = (op_q == flm_pkg::OP_CLR_HIST);
		assign ctrl_w[a].rec       = item_q;

		flm_row #(
			.LIST_DEPTH    (LIST_DEPTH),
			.HISTORY_DEPTH (HISTORY_DEPTH),
			.CNT_W         (CNT_W)
		) u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl_w[a]),
			.stat   (stat_w[a]),
			.count  (cnt_w[a])
		);
	end

	// Build the result from the addressed row
	assign cnt_ext = {4'b0000, sel_cnt};
	always_comb begin
		res                = '0;
		res.fault_active   = (sel_cnt != '0);
		res.fault_count    = cnt_ext[3:0];
		res.head_code      = sel_stat.cur_nxt.code;
		res.head_clearable = sel_stat.cur_nxt.clr;
		res.head_stop      = sel_stat.cur_nxt.stop;
		res.head_history   = sel_stat.cur_nxt.hist;
		res.newest_logged  = sel_stat.newest;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin_take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

	// Checks
	`FLM_ASSERT_NXT(a_accept_starts_exec, clk, arst_n, in_xfer, state_q == S_EXEC)
	`FLM_ASSERT_IMP(a_finish_list_packed, clk, arst_n, state_q == S_FINISH, !sel_stat.pending)
	`FLM_ASSERT_IMP(a_result_from_finish, clk, arst_n, $rose(m_tvalid), $past(state_q) == S_FINISH)
	`FLM_ASSERT_NXT(a_report_sets_active, clk, arst_n,
		fin_take && (op_q == flm_pkg::OP_REPORT) && code_nz && axis_ok,
		m_tvalid && m_tdata[0])

endmodule

`default_nettype wire
